// ----- hdl/sta_pkg.sv -----
package sta_pkg;

    localparam int DATA_W    = 32;
    localparam int COUNT_W   = 5;
    localparam int SLOT_W    = 4;
    localparam int DIV_STEPS = 32;

    localparam logic [DATA_W-1:0] ALIGN_RESET = 32'd4096;
    localparam logic [DATA_W-1:0] ALL_ONES    = 32'hFFFF_FFFF;

    // opcodes of an input word
    localparam logic OP_LOAD      = 1'b0;
    localparam logic OP_TRANSLATE = 1'b1;

    // register index, taken from paddr[2]
    localparam logic REG_ALIGN = 1'b0;
    localparam logic REG_COUNT = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_EVAL,
        ST_SCAN,
        ST_DONE
    } state_t;

    // strobes from the sequencer to every cell
    typedef struct packed {
        logic start;
        logic step;
        logic eval;
    } cell_ctrl_t;

    // slot write broadcast to the cells
    typedef struct packed {
        logic              we;
        logic [SLOT_W-1:0] idx;
        logic [DATA_W-1:0] start;
        logic [DATA_W-1:0] size;
        logic [DATA_W-1:0] raw;
    } slot_load_t;

    // result handed from one cell to the next
    typedef struct packed {
        logic              found;
        logic [DATA_W-1:0] value;
    } link_t;

endpackage

// ----- hdl/sta_cell.sv -----
module sta_cell #(
    parameter int CELL_INDEX = 0
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  sta_pkg::cell_ctrl_t              ctrl,
    input  sta_pkg::slot_load_t              load,
    input  logic [sta_pkg::DATA_W-1:0]       align,
    input  logic [sta_pkg::COUNT_W-1:0]      count,
    input  logic [sta_pkg::DATA_W-1:0]       rva,
    input  logic                             want,
    input  sta_pkg::link_t                   link_in,
    output sta_pkg::link_t                   link_out,
    output logic [sta_pkg::DATA_W-1:0]       slot_start
);

    logic [sta_pkg::DATA_W-1:0] start_reg;
    logic [sta_pkg::DATA_W-1:0] size_reg;
    logic [sta_pkg::DATA_W-1:0] raw_reg;
    logic [sta_pkg::DATA_W-1:0] num_reg;
    logic [sta_pkg::DATA_W-1:0] rem_reg;
    logic [sta_pkg::DATA_W-1:0] val_reg;
    logic                       hit_reg;
    logic                       found_reg;
    logic [sta_pkg::DATA_W-1:0] value_reg;

    logic [sta_pkg::DATA_W:0]   shifted;
    logic [sta_pkg::DATA_W:0]   diff;
    logic [sta_pkg::DATA_W-1:0] rem_next;
    logic [sta_pkg::DATA_W-1:0] sum;
    logic [sta_pkg::DATA_W-1:0] rounded;
    logic [sta_pkg::DATA_W-1:0] offset;
    logic [sta_pkg::DATA_W-1:0] val_next;
    logic                       active;
    logic                       hit_next;
    logic                       slot_we;

    // one restoring remainder step per cycle
    assign shifted  = {rem_reg, num_reg[sta_pkg::DATA_W-1]};
    assign diff     = shifted - {1'b0, align};
    assign rem_next = (shifted >= {1'b0, align}) ? diff[sta_pkg::DATA_W-1:0]
                                                 : shifted[sta_pkg::DATA_W-1:0];

    assign sum     = start_reg + size_reg;
    assign rounded = ((align == '0) || (rem_reg == '0)) ? sum : (sum - rem_reg + align);
    assign active  = 32'(count) > 32'(CELL_INDEX);
    assign hit_next = active && (rva >= start_reg) && (rva < rounded);
    assign offset   = rva - start_reg;
    assign val_next = want ? offset : (offset + raw_reg);

    assign slot_we = load.we && (32'(load.idx) == 32'(CELL_INDEX));

    always_ff @(posedge clk)
    begin
        if (slot_we)
        begin
            start_reg <= load.start;
            size_reg  <= load.size;
            raw_reg   <= load.raw;
        end
        if (ctrl.start)
        begin
            num_reg <= sum;
            rem_reg <= '0;
        end
        else if (ctrl.step)
        begin
            num_reg <= {num_reg[sta_pkg::DATA_W-2:0], 1'b0};
            rem_reg <= rem_next;
        end
        if (ctrl.eval)
        begin
            val_reg <= val_next;
        end
        value_reg <= link_in.found ? link_in.value : val_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg   <= 1'b0;
            found_reg <= 1'b0;
        end
        else if (ctrl.start)
        begin
            hit_reg   <= 1'b0;
            found_reg <= 1'b0;
        end
        else
        begin
            if (ctrl.eval)
            begin
                hit_reg <= hit_next;
            end
            found_reg <= link_in.found | hit_reg;
        end
    end

    assign link_out.found = found_reg;
    assign link_out.value = value_reg;
    assign slot_start     = start_reg;

endmodule

// ----- hdl/sta_ctrl.sv -----
module sta_ctrl #(
    parameter int MAX_SECTIONS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                translate_fire,
    input  logic                out_free,
    output logic                in_ready,
    output logic                finish,
    output sta_pkg::cell_ctrl_t cell_ctrl
);

    localparam int CNT_LIMIT = (MAX_SECTIONS > sta_pkg::DIV_STEPS) ? MAX_SECTIONS
                                                                   : sta_pkg::DIV_STEPS;
    localparam int CNT_W = $clog2(CNT_LIMIT);

    sta_pkg::state_t  state_reg;
    sta_pkg::state_t  state_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             div_last;
    logic             scan_last;

    assign div_last  = cnt_reg == CNT_W'(sta_pkg::DIV_STEPS - 1);
    assign scan_last = cnt_reg == CNT_W'(MAX_SECTIONS - 1);

    // ready depends on the state alone, so it never loops back through the handshake
    assign in_ready = (state_reg == sta_pkg::ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sta_pkg::ST_IDLE:
            begin
                if (translate_fire)
                begin
                    state_next = sta_pkg::ST_DIVIDE;
                end
            end
            sta_pkg::ST_DIVIDE:
            begin
                if (div_last)
                begin
                    state_next = sta_pkg::ST_EVAL;
                end
            end
            sta_pkg::ST_EVAL:
            begin
                state_next = sta_pkg::ST_SCAN;
            end
            sta_pkg::ST_SCAN:
            begin
                if (scan_last)
                begin
                    state_next = sta_pkg::ST_DONE;
                end
            end
            sta_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = sta_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sta_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        finish    = 1'b0;
        cell_ctrl = '0;
        cnt_next  = '0;
        unique case (state_reg)
            sta_pkg::ST_IDLE:
            begin
                cell_ctrl.start = translate_fire;
            end
            sta_pkg::ST_DIVIDE:
            begin
                cell_ctrl.step = 1'b1;
                cnt_next       = div_last ? '0 : cnt_reg + CNT_W'(1);
            end
            sta_pkg::ST_EVAL:
            begin
                cell_ctrl.eval = 1'b1;
            end
            sta_pkg::ST_SCAN:
            begin
                cnt_next = scan_last ? '0 : cnt_reg + CNT_W'(1);
            end
            sta_pkg::ST_DONE:
            begin
                finish = out_free;
            end
            default:
            begin
                cnt_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sta_pkg::ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

// ----- hdl/section_table_address_translator.sv -----
// Section table address translator. Load words (opcode 0) write one slot of
// the section table (start, size, raw pointer) and give no result; a load
// to a slot beyond the table is dropped. Translate words (opcode 1) map an
// RVA to a file offset or, with want_section_offset set, to the offset in
// its section; an RVA below slot 0's start passes through unchanged, and a
// miss returns all ones with matched low. Slot 0 must be loaded before any
// translate, and every slot below section_count before a scan reaches it.
// Timing: a load is taken while the block is idle. A translate occupies the
// block from acceptance until its result word is loaded into the output
// register, and that load waits while an earlier word still sits there. The
// steps are a bit-serial remainder, run in all slot cells at once against
// section_alignment, one evaluation step, a pass down the cell chain, one
// cell at a time, that carries the first hit, and the load of the output
// register. A finished word waits in the output register while the next
// word is taken.
// Registers: section_alignment at 0x0 (reset 4096, 0 means no rounding),
// section_count at 0x4 (reset 0, 5 bits, values above the depth scan all).
module section_table_address_translator #(
    parameter int MAX_SECTIONS = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,

    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [2:0]                         paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready,

    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic                               opcode,
    input  logic [sta_pkg::SLOT_W-1:0]         slot_index,
    input  logic [sta_pkg::DATA_W-1:0]         section_start,
    input  logic [sta_pkg::DATA_W-1:0]         section_size,
    input  logic [sta_pkg::DATA_W-1:0]         raw_pointer,
    input  logic [sta_pkg::DATA_W-1:0]         rva,
    input  logic                               want_section_offset,

    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [sta_pkg::DATA_W-1:0]         translated,
    output logic                               matched
);

    logic [sta_pkg::DATA_W-1:0]  align_reg;
    logic [sta_pkg::COUNT_W-1:0] count_reg;
    logic [sta_pkg::DATA_W-1:0]  rva_reg;
    logic                        want_reg;
    logic                        out_valid_reg;
    logic [sta_pkg::DATA_W-1:0]  translated_reg;
    logic                        matched_reg;

    logic                        cfg_we;
    logic                        in_fire;
    logic                        translate_fire;
    logic                        out_free;
    logic                        finish;
    logic                        pass;
    sta_pkg::cell_ctrl_t         cell_ctrl;
    sta_pkg::slot_load_t         load;
    sta_pkg::link_t              chain [MAX_SECTIONS+1];
    logic [sta_pkg::DATA_W-1:0]  slot_starts [MAX_SECTIONS];

    // ---- configuration port: no wait states, write on the access phase
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;

    always_comb
    begin
        unique case (paddr[2])
            sta_pkg::REG_ALIGN: prdata = align_reg;
            sta_pkg::REG_COUNT: prdata = {{(32-sta_pkg::COUNT_W){1'b0}}, count_reg};
            default:            prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            align_reg <= sta_pkg::ALIGN_RESET;
            count_reg <= '0;
        end
        else if (cfg_we)
        begin
            if (paddr[2] == sta_pkg::REG_ALIGN)
            begin
                align_reg <= pwdata;
            end
            else
            begin
                count_reg <= pwdata[sta_pkg::COUNT_W-1:0];
            end
        end
    end

    // ---- input side
    assign in_fire        = in_valid && in_ready;
    assign translate_fire = in_fire && (opcode == sta_pkg::OP_TRANSLATE);

    assign load.we    = in_fire && (opcode == sta_pkg::OP_LOAD);
    assign load.idx   = slot_index;
    assign load.start = section_start;
    assign load.size  = section_size;
    assign load.raw   = raw_pointer;

    // the address and mode stay put for the whole scan
    always_ff @(posedge clk)
    begin
        if (translate_fire)
        begin
            rva_reg  <= rva;
            want_reg <= want_section_offset;
        end
    end

    // ---- sequencer
    sta_ctrl #(
        .MAX_SECTIONS (MAX_SECTIONS)
    ) u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .translate_fire (translate_fire),
        .out_free       (out_free),
        .in_ready       (in_ready),
        .finish         (finish),
        .cell_ctrl      (cell_ctrl)
    );

    // ---- chain of slot cells; the earliest hit wins as the word moves down
    assign chain[0] = '0;

    for (genvar i = 0; i < MAX_SECTIONS; i++)
    begin : g_cell
        sta_cell #(
            .CELL_INDEX (i)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (cell_ctrl),
            .load       (load),
            .align      (align_reg),
            .count      (count_reg),
            .rva        (rva_reg),
            .want       (want_reg),
            .link_in    (chain[i]),
            .link_out   (chain[i+1]),
            .slot_start (slot_starts[i])
        );
    end

    // below slot 0 the address is not in any section and passes through
    assign pass = rva_reg < slot_starts[0];

    // ---- output register
    assign out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            if (pass)
            begin
                translated_reg <= rva_reg;
                matched_reg    <= 1'b1;
            end
            else
            begin
                translated_reg <= chain[MAX_SECTIONS].found ? chain[MAX_SECTIONS].value
                                                            : sta_pkg::ALL_ONES;
                matched_reg    <= chain[MAX_SECTIONS].found;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign translated = translated_reg;
    assign matched    = matched_reg;

endmodule
